/* src/assert_macros.svh */
// Assertion macros shared by the battery monitor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked on clk and masked while rst_n is low
`define BLAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication from a condition to a consequence in the same cycle
`define BLAM_ASSERT_IMPL(label, ante, cons, msg) \
    `BLAM_ASSERT(label, ((ante) |-> (cons)), msg)

`endif

/* src/blam_pkg.sv */
// Shared types, constants and widths for the battery level monitor
package blam_pkg;

    localparam int ADC_BITS   = 12;
    localparam int SAMPLES    = 16;

    localparam int SAMPLE_W   = ADC_BITS;
    localparam int SUM_W      = ADC_BITS + $clog2(SAMPLES);
    localparam int CNT_W      = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int MV_W       = 16;
    localparam int PCT_W      = 7;
    localparam int LVL_W      = 2;
    localparam int PROD_W     = SUM_W + MV_W;
    localparam int MV_SHIFT   = ADC_BITS + $clog2(SAMPLES);
    localparam int SCALED_W   = MV_W + PCT_W;
    localparam int DVD_W      = SCALED_W;
    localparam int DSR_W      = 16;
    localparam int DCNT_W     = $clog2(DVD_W + 1);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
    localparam logic [MV_W-1:0]  MV_MAX   = {MV_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_PCT   = 3'd4;

    typedef enum logic [LVL_W-1:0] {
        LVL_OK   = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_CRIT = 2'd2
    } level_t;

    typedef struct packed {
        logic [MV_W-1:0]  full_scale_mv;
        logic [MV_W-1:0]  full_mv;
        logic [MV_W-1:0]  empty_mv;
        logic [PCT_W-1:0] low_pct;
        logic [PCT_W-1:0] critical_pct;
    } cfg_t;

    typedef struct packed {
        logic             complete;
        logic [SUM_W-1:0] sum;
    } cmd_t;

    typedef struct packed {
        logic             reading_valid;
        logic [MV_W-1:0]  voltage_mv;
        logic [PCT_W-1:0] percent;
        level_t           alert_level;
        logic             alert_changed;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* src/blam_front.sv */
// Front end: sample accumulation and reading command generation
module blam_front
    import blam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] adc_sample,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_cmd
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [SUM_W-1:0] sum_add;
    logic             last;

    assign q_push       = push & ~q_full;
    assign last         = (cnt_reg == CNT_W'(SAMPLES - 1));
    assign sum_add      = sum_reg + SUM_W'(adc_sample);
    assign q_cmd.complete = last;
    assign q_cmd.sum    = sum_add;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (q_push)
        begin
            if (last)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_add;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/blam_cmdq.sv */
// Command queue between front end and back end
module blam_cmdq
    import blam_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t rdata
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (QPTR_W + 1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* src/blam_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle
module blam_div
    import blam_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DCNT_W'(1));
            if (req.start)
            begin
                cnt_reg  <= DCNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

/* src/blam_back.sv */
// Back end: voltage scaling, percent mapping, level classification and result register
module blam_back
    import blam_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_empty,
    input  cmd_t     q_cmd,
    output logic     q_pop,
    output div_req_t div_req,
    input  div_rsp_t div_rsp,
    input  logic     pop,
    output logic     out_valid,
    output result_t  res
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_PCT  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_CLS  = 5'b10000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] dsr_next;
    logic             start_reg;
    logic             start_next;
    logic [MV_W-1:0]  mv_reg;
    logic [MV_W-1:0]  mv_next;
    logic [PCT_W-1:0] pct_reg;
    logic [PCT_W-1:0] pct_next;
    level_t           level_reg;
    level_t           level_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          res_reg;
    result_t          res_next;

    logic                slot_free;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   prod_mv;
    logic [MV_W-1:0]     diff_mv;
    logic [SCALED_W-1:0] scaled;
    level_t              lvl_c;

    assign slot_free = ~out_valid_reg | pop;
    assign prod      = PROD_W'(sum_reg) * PROD_W'(cfg.full_scale_mv);
    assign prod_mv   = prod >> MV_SHIFT;
    assign diff_mv   = mv_reg - cfg.empty_mv;
    assign scaled    = SCALED_W'(diff_mv) * SCALED_W'(PCT_FULL);

    assign lvl_c = (pct_reg <= cfg.critical_pct) ? LVL_CRIT :
                   (pct_reg <= cfg.low_pct)      ? LVL_LOW  : LVL_OK;

    assign div_req.start    = start_reg;
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dsr_reg;
    assign out_valid        = out_valid_reg;
    assign res              = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        start_next     = 1'b0;
        mv_next        = mv_reg;
        pct_next       = pct_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg & ~pop;
        res_next       = res_reg;
        q_pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.complete)
                    begin
                        sum_next   = q_cmd.sum;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        res_next.reading_valid = 1'b0;
                        res_next.voltage_mv    = '0;
                        res_next.percent       = '0;
                        res_next.alert_level   = level_reg;
                        res_next.alert_changed = 1'b0;
                        out_valid_next         = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                // scale the sum, drop the converter and averaging bits, saturate
                mv_next    = (prod_mv > PROD_W'(MV_MAX)) ? MV_MAX : prod_mv[MV_W-1:0];
                state_next = ST_PCT;
            end
            ST_PCT:
            begin
                if (mv_reg >= cfg.full_mv)
                begin
                    pct_next   = PCT_FULL;
                    state_next = ST_CLS;
                end
                else if (mv_reg <= cfg.empty_mv)
                begin
                    pct_next   = '0;
                    state_next = ST_CLS;
                end
                else
                begin
                    dvd_next   = DVD_W'(scaled);
                    dsr_next   = cfg.full_mv - cfg.empty_mv;
                    start_next = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    pct_next   = div_rsp.quotient[PCT_W-1:0];
                    state_next = ST_CLS;
                end
            end
            ST_CLS:
            begin
                if (slot_free)
                begin
                    res_next.reading_valid = 1'b1;
                    res_next.voltage_mv    = mv_reg;
                    res_next.percent       = pct_reg;
                    res_next.alert_level   = lvl_c;
                    res_next.alert_changed = (lvl_c != level_reg);
                    level_next             = lvl_c;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        mv_reg  <= mv_next;
        pct_reg <= pct_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            level_reg     <= LVL_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/battery_level_alert_monitor.sv */
// Top level of the battery level monitor: configuration registers and block wiring
//
// Each pushed ADC sample gives one result word. Samples are summed in the
// front end and handed through a four-word command queue to the back end.
// A sample that does not finish a reading is answered from the idle state
// of the back end; the sample that finishes a reading passes through the
// scaling, percent and classification states, with the bit-serial divider
// forming the percent in between, or with no division when the voltage lies
// at or beyond full or empty. The back end takes no new command until it is
// idle and its result register is free or being popped. Full rises only
// when the command queue fills. Write configuration only while no word is
// in flight and the result queue is empty.
module battery_level_alert_monitor
    import blam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    output logic                  empty,
    input  logic                  pop,
    output logic                  reading_valid,
    output logic [MV_W-1:0]       voltage_mv,
    output logic [PCT_W-1:0]      percent,
    output logic [LVL_W-1:0]      alert_level,
    output logic                  alert_changed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t     cfg_reg;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    cmd_t     q_wcmd;
    cmd_t     q_rcmd;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     out_valid;
    result_t  res;

    assign full          = q_full;
    assign empty         = ~out_valid;
    assign reading_valid = res.reading_valid;
    assign voltage_mv    = res.voltage_mv;
    assign percent       = res.percent;
    assign alert_level   = res.alert_level;
    assign alert_changed = res.alert_changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale_mv <= MV_W'(6600);
            cfg_reg.full_mv       <= MV_W'(4200);
            cfg_reg.empty_mv      <= MV_W'(3300);
            cfg_reg.low_pct       <= PCT_W'(20);
            cfg_reg.critical_pct  <= PCT_W'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_FULL_SCALE: cfg_reg.full_scale_mv <= cfg_wdata;
                REG_FULL_MV:    cfg_reg.full_mv       <= cfg_wdata;
                REG_EMPTY_MV:   cfg_reg.empty_mv      <= cfg_wdata;
                REG_LOW_PCT:    cfg_reg.low_pct       <= cfg_wdata[PCT_W-1:0];
                REG_CRIT_PCT:   cfg_reg.critical_pct  <= cfg_wdata[PCT_W-1:0];
                default:        cfg_reg               <= cfg_reg;
            endcase
        end
    end

    blam_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .adc_sample (adc_sample),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_wcmd)
    );

    blam_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wcmd),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .rdata (q_rcmd)
    );

    blam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    blam_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_cmd     (q_rcmd),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .pop       (pop),
        .out_valid (out_valid),
        .res       (res)
    );

`include "assert_macros.svh"

    `BLAM_ASSERT_IMPL(a_pct_range, !empty, percent <= PCT_FULL, "percent above full scale")
    `BLAM_ASSERT_IMPL(a_partial_word, !empty && !reading_valid,
        voltage_mv == '0 && percent == '0 && !alert_changed, "partial word carries a reading")
    `BLAM_ASSERT_IMPL(a_crit_class, !empty && reading_valid && percent <= cfg_reg.critical_pct,
        alert_level == LVL_CRIT, "reading at critical threshold not flagged critical")

endmodule

/* dv/blam_reading_checker.sv */
// Reading checker: predicts every result word of the battery monitor and compares it
`timescale 1ns / 100ps

module blam_reading_checker
    import blam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    input  logic                  empty,
    input  logic                  pop,
    input  logic                  reading_valid,
    input  logic [MV_W-1:0]       voltage_mv,
    input  logic [PCT_W-1:0]      percent,
    input  logic [LVL_W-1:0]      alert_level,
    input  logic                  alert_changed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    readings_done,
    output int                    level_changes
);

    localparam longint unsigned PCT_SCALE   = 100;
    localparam longint unsigned SUM_DIVISOR = 64'(SAMPLES) << ADC_BITS;

    cfg_t            regs;
    longint unsigned acc_sum;
    int unsigned     acc_cnt;
    level_t          acc_level;
    result_t         expected_words[$];

    function automatic result_t predict_word(input logic [SAMPLE_W-1:0] s);
        result_t         w;
        longint unsigned mv;
        longint unsigned above;
        longint unsigned span;
        w = '0;
        acc_sum += s;
        acc_cnt++;
        if (acc_cnt < SAMPLES)
        begin
            w.alert_level = acc_level;
            return w;
        end
        mv = (acc_sum * regs.full_scale_mv) / SUM_DIVISOR;
        w.reading_valid = 1'b1;
        w.voltage_mv = (mv > MV_MAX) ? MV_MAX : mv[MV_W-1:0];
        if (w.voltage_mv >= regs.full_mv)
            w.percent = PCT_FULL;
        else if (w.voltage_mv <= regs.empty_mv)
            w.percent = '0;
        else
        begin
            above = w.voltage_mv - regs.empty_mv;
            span = regs.full_mv - regs.empty_mv;
            w.percent = PCT_W'((above * PCT_SCALE) / span);
        end
        if (w.percent <= regs.critical_pct)
            w.alert_level = LVL_CRIT;
        else if (w.percent <= regs.low_pct)
            w.alert_level = LVL_LOW;
        else
            w.alert_level = LVL_OK;
        w.alert_changed = (w.alert_level != acc_level);
        acc_level = w.alert_level;
        acc_sum = 0;
        acc_cnt = 0;
        return w;
    endfunction

    function automatic void compare_field(input string name, input logic [MV_W-1:0] want,
                                          input logic [MV_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_word();
        result_t w;
        if (expected_words.size() == 0)
        begin
            $display("%0t: result word with none expected, expected nothing, actual mv %0d pct %0d",
                     $time, voltage_mv, percent);
            mismatches++;
            return;
        end
        w = expected_words.pop_front();
        compare_field("reading_valid", w.reading_valid, reading_valid);
        compare_field("voltage_mv", w.voltage_mv, voltage_mv);
        compare_field("percent", w.percent, percent);
        compare_field("alert_level", w.alert_level, alert_level);
        compare_field("alert_changed", w.alert_changed, alert_changed);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t w;
        if (!rst_n)
        begin
            regs = '{full_scale_mv: 16'd6600, full_mv: 16'd4200, empty_mv: 16'd3300,
                     low_pct: 7'd20, critical_pct: 7'd10};
            acc_sum = 0;
            acc_cnt = 0;
            acc_level = LVL_OK;
            expected_words.delete();
            mismatches = 0;
            outstanding = 0;
            readings_done = 0;
            level_changes = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_FULL_SCALE: regs.full_scale_mv = cfg_wdata;
                    REG_FULL_MV:    regs.full_mv = cfg_wdata;
                    REG_EMPTY_MV:   regs.empty_mv = cfg_wdata;
                    REG_LOW_PCT:    regs.low_pct = cfg_wdata[PCT_W-1:0];
                    REG_CRIT_PCT:   regs.critical_pct = cfg_wdata[PCT_W-1:0];
                    default:        ;
                endcase
            end
            if (pop && !empty)
                check_word();
            if (push && !full)
            begin
                w = predict_word(adc_sample);
                expected_words.push_back(w);
                readings_done += w.reading_valid;
                level_changes += w.alert_changed;
            end
            outstanding = expected_words.size();
        end
    end

endmodule

/* dv/battery_level_alert_monitor_tb.sv */
// Testbench top: sample stimulus, register settings, result draining and the verdict
`timescale 1ns / 100ps

module battery_level_alert_monitor_tb;
    import blam_pkg::*;

    localparam int ITEMS_TARGET  = 1600;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SAMPLE    = (1 << SAMPLE_W) - 1;
    localparam int FULL_CODE     = 1 << ADC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER[5] =
        '{REG_FULL_SCALE, REG_FULL_MV, REG_EMPTY_MV, REG_LOW_PCT, REG_CRIT_PCT};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [SAMPLE_W-1:0]   adc_sample = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  reading_valid;
    logic [MV_W-1:0]       voltage_mv;
    logic [PCT_W-1:0]      percent;
    logic [LVL_W-1:0]      alert_level;
    logic                  alert_changed;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int readings_done;
    int level_changes;

    int   samples_sent = 0;
    int   settings_used = 1;
    int   idle_cycles = 0;
    int   set_fs = 6600;
    int   set_full = 4200;
    int   set_empty = 3300;
    int   set_low = 20;
    int   set_crit = 10;
    logic pop_taken = 1'b0;
    int   pop_wait = 0;
    bit   out_steady = 1'b0;

    battery_level_alert_monitor DUT (.*);

    blam_reading_checker u_checker (.*);

    always #4 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // pick a sample code whose reading lands near the percent scale or its thresholds
    function automatic int pick_level();
        int lo_mv;
        int hi_mv;
        int margin;
        int t;
        int pct;
        if (set_fs == 0 || $urandom_range(0, 5) == 0)
            return $urandom_range(0, MAX_SAMPLE);
        lo_mv = (set_full < set_empty) ? set_full : set_empty;
        hi_mv = set_full + set_empty - lo_mv;
        margin = (hi_mv - lo_mv) / 4 + 50;
        case ($urandom_range(0, 9))
            0:       t = set_full;
            1:       t = set_empty;
            2, 3:
            begin
                pct = ($urandom_range(0, 1) ? set_low : set_crit) + $urandom_range(0, 2) - 1;
                pct = (pct < 0) ? 0 : pct;
                t = set_empty + pct * (hi_mv - lo_mv) / 100;
            end
            default: t = $urandom_range(lo_mv > margin ? lo_mv - margin : 0, hi_mv + margin);
        endcase
        t = (t * FULL_CODE + set_fs - 1) / set_fs;
        return (t > MAX_SAMPLE) ? MAX_SAMPLE : t;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit steady);
        int gap;
        adc_sample <= s;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        samples_sent++;
        @(negedge clk);
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic run_samples(input int n);
        bit steady;
        bit noisy;
        int base;
        int jitter;
        int s;
        steady = ($urandom_range(0, 3) == 0);
        base = pick_level();
        jitter = 0;
        noisy = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (samples_sent % SAMPLES == 0)
            begin
                base = pick_level();
                case ($urandom_range(0, 3))
                    0:       jitter = 0;
                    1:       jitter = 1;
                    2:       jitter = 4;
                    default: jitter = 32;
                endcase
                noisy = ($urandom_range(0, 9) == 0);
            end
            if (noisy)
                s = $urandom_range(0, MAX_SAMPLE);
            else
            begin
                s = base + $urandom_range(0, 2 * jitter) - jitter;
                s = (s < 0) ? 0 : (s > MAX_SAMPLE) ? MAX_SAMPLE : s;
            end
            send_sample(SAMPLE_W'(s), steady);
        end
    endtask

    // write all registers back to back once the block has drained
    task automatic program_regs(input logic [CFG_DATA_W-1:0] fs, input logic [CFG_DATA_W-1:0] fm,
                                input logic [CFG_DATA_W-1:0] em, input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] cr);
        logic [CFG_DATA_W-1:0] vals[5];
        vals = '{fs, fm, em, lo, cr};
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_idx <= REG_ORDER[i];
            cfg_wdata <= vals[i];
            @(negedge clk);
        end
        cfg_idx <= CFG_IDX_W'(REG_CRIT_PCT + $urandom_range(1, 3));
        cfg_wdata <= CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        set_fs = fs;
        set_full = fm;
        set_empty = em;
        set_low = lo[PCT_W-1:0];
        set_crit = cr[PCT_W-1:0];
        settings_used++;
    endtask

    task automatic random_setting();
        logic [CFG_DATA_W-1:0] fs;
        logic [CFG_DATA_W-1:0] fm;
        logic [CFG_DATA_W-1:0] em;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] cr;
        fs = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 16'hFFFF) :
                                                $urandom_range(3000, 9000));
        if ($urandom_range(0, 1))
        begin
            em = CFG_DATA_W'($urandom_range(0, 5000));
            fm = em + CFG_DATA_W'($urandom_range(1, 3000));
        end
        else
        begin
            em = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            fm = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            lo = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            cr = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        end
        else
        begin
            lo = CFG_DATA_W'($urandom_range(0, 100));
            cr = CFG_DATA_W'($urandom_range(0, lo));
        end
        program_regs(fs, fm, em, lo, cr);
    endtask

    always @(posedge clk)
        pop_taken <= pop && !empty;

    always @(negedge clk)
    begin : drain_ctl
        int g;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_wait <= 0;
        end
        else if (pop_wait > 0)
        begin
            pop <= 1'b0;
            pop_wait <= pop_wait - 1;
        end
        else
        begin
            if (pop_taken && $urandom_range(0, 299) == 0)
                out_steady = !out_steady;
            g = (pop_taken && !out_steady) ? idle_len() : 0;
            pop <= (g == 0);
            pop_wait <= (g > 0) ? g - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // a reading of zeros closed by one full-scale sample, then full-scale samples and bit patterns
        for (int i = 0; i < 15; i++)
            send_sample('0, 1'b0);
        send_sample(SAMPLE_W'(MAX_SAMPLE), 1'b0);
        for (int i = 0; i < 6; i++)
            send_sample(SAMPLE_W'(MAX_SAMPLE), 1'b0);
        send_sample(SAMPLE_W'(12'h555), 1'b0);
        send_sample(SAMPLE_W'(12'hAAA), 1'b0);
        run_samples(150);

        program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'd100, 16'd0);
        run_samples(150);
        program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_samples(60);
        program_regs(16'd6600, 16'd2500, 16'd2500, 16'd50, 16'd25);
        run_samples(150);
        program_regs(16'd6600, 16'd3000, 16'd4000, 16'd60, 16'd30);
        run_samples(150);
        program_regs(16'd6600, 16'd4200, 16'd3300, 16'hFFFF, 16'hFF65);
        run_samples(120);
        program_regs(16'd5000, 16'd4000, 16'd1000, 16'hFF85, 16'd40);
        run_samples(150);
        program_regs(16'd6600, 16'd4200, 16'd3300, 16'd20, 16'd10);
        run_samples(150);
        while (samples_sent < ITEMS_TARGET)
        begin
            random_setting();
            run_samples($urandom_range(60, 200));
        end

        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d samples, %0d complete readings, %0d level changes,",
                 samples_sent, readings_done, level_changes);
        $display("across %0d register settings including extremes and masked thresholds.",
                 settings_used);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/blam_pkg.sv
src/blam_front.sv
src/blam_cmdq.sv
src/blam_div.sv
src/blam_back.sv
src/battery_level_alert_monitor.sv
dv/blam_reading_checker.sv
dv/battery_level_alert_monitor_tb.sv
